[design/gcpsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcpsd_pkg: shared constants for the Gray code phase shift decoder
// Holds register indexes, datapath widths, the CORDIC arctangent table and
// the fixed-point constants that the decoder modules share.
// ----------------------------------------------------------------------------
package gcpsd_pkg;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_PHASE_STEPS   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_BIN_THRESHOLD = 1'd1;

  localparam logic [2:0] STEPS_THREE     = 3'd3;
  localparam logic [2:0] STEPS_RESET     = 3'd4;
  localparam logic [7:0] THRESHOLD_RESET = 8'd128;

  localparam int GrayInputs = 5;
  localparam int DiffW      = 10;
  localparam int XyW        = 34;
  localparam int AngW       = 32;
  localparam int Q20Shift   = 20;
  localparam logic signed [22:0] SQRT3_Q20 = 23'sd1816187;

  localparam int CordicIters = 28;
  localparam logic [AngW-1:0] ATAN_TURN [CordicIters] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };
  localparam logic [AngW-1:0] ANG_ZERO    = 32'h00000000;
  localparam logic [AngW-1:0] ANG_QUARTER = 32'h40000000;
  localparam logic [AngW-1:0] ANG_HALF    = 32'h80000000;
  localparam logic [AngW-1:0] ANG_3QUART  = 32'hC0000000;

  localparam int SumSqW     = 20;
  localparam int IsqrtIters = SumSqW / 2;
  localparam int RootW      = IsqrtIters + 1;
  localparam logic [10:0] RECIP3 = 11'd683;

endpackage
`default_nettype wire

[design/gray_code_phase_shift_decoder.sv]
`default_nettype none
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while a finished result is stalled at the output register.
// The depth is set by the CORDIC angle pipeline.
// Reset clears the valid bits and sets phase_steps to 4 and the threshold
// to 128; no clearing pass is needed.
// ----------------------------------------------------------------------------
// gray_code_phase_shift_decoder: structured-light per-pixel decoder
// Combines a phase-shift wrapped phase with complementary Gray code orders.
// Five binarizer lanes work in parallel on the Gray samples; their bits are
// merged into a short and a long binary order. A CORDIC pipeline finds the
// wrapped phase and a square-root pipeline the modulation; the three-zone
// complementary rule then picks the order added to the phase.
// ----------------------------------------------------------------------------
module gray_code_phase_shift_decoder
  import gcpsd_pkg::*;
#(
  parameter int GRAY_BITS       = 4,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         phase_sample_0_i,
  input  wire logic [7:0]         phase_sample_1_i,
  input  wire logic [7:0]         phase_sample_2_i,
  input  wire logic [7:0]         phase_sample_3_i,
  input  wire logic [7:0]         gray_sample_0_i,
  input  wire logic [7:0]         gray_sample_1_i,
  input  wire logic [7:0]         gray_sample_2_i,
  input  wire logic [7:0]         gray_sample_3_i,
  input  wire logic [7:0]         gray_sample_4_i,
  input  wire logic [7:0]         black_sample_i,
  input  wire logic [7:0]         white_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [21:0]      unwrapped_phase_o,
  output logic [7:0]              modulation_o
);

  localparam int Lat    = CordicIters + 4;
  localparam int KDly   = CordicIters + 1;
  localparam int MDly   = CordicIters - IsqrtIters - 1;
  localparam int KW     = GRAY_BITS + 2;
  localparam int LongW  = GRAY_BITS + 1;
  localparam int WideW  = PHASE_FRAC_BITS + KW + 24;

  // Configuration registers.
  logic [2:0] steps_q;
  logic [7:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
      thr_q   <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PHASE_STEPS:   steps_q <= cfg_data_i[2:0];
        REG_BIN_THRESHOLD: thr_q   <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // The pipeline moves as a whole unless the output holds a stalled result.
  logic en;
  logic [Lat-1:0] v_q;

  assign en          = !(v_q[Lat-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], in_valid_i};
    end
  end

  // Stage 1: fringe differences and the pixel's own min and span.
  logic             three;
  logic signed [DiffW-1:0] cx, dd;
  logic [7:0]       gs [GrayInputs];
  logic [7:0]       all_s [7];
  logic [7:0]       lo, hi;

  always_comb begin
    three = (steps_q == STEPS_THREE);
    if (three) begin
      cx = (DiffW'(phase_sample_0_i) <<< 1) - DiffW'(phase_sample_1_i)
           - DiffW'(phase_sample_2_i);
      dd = DiffW'(phase_sample_1_i) - DiffW'(phase_sample_2_i);
    end else begin
      cx = DiffW'(phase_sample_0_i) - DiffW'(phase_sample_2_i);
      dd = DiffW'(phase_sample_1_i) - DiffW'(phase_sample_3_i);
    end
    gs[0] = gray_sample_0_i;
    gs[1] = gray_sample_1_i;
    gs[2] = gray_sample_2_i;
    gs[3] = gray_sample_3_i;
    gs[4] = gray_sample_4_i;
    for (int i = 0; i < GrayInputs; i++) all_s[i] = gs[i];
    all_s[5] = black_sample_i;
    all_s[6] = white_sample_i;
    lo = all_s[0];
    hi = all_s[0];
    for (int i = 1; i < 7; i++) begin
      if (all_s[i] < lo) lo = all_s[i];
      if (all_s[i] > hi) hi = all_s[i];
    end
  end

  logic signed [DiffW-1:0] cx1_q, dd1_q;
  logic                    three1_q;
  logic [7:0]              gs1_q [GrayInputs];
  logic [7:0]              lo1_q, span1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q    <= cx;
      dd1_q    <= dd;
      three1_q <= three;
      gs1_q    <= gs;
      lo1_q    <= lo;
      span1_q  <= hi - lo;
    end
  end

  // Stage 2: binarizer lanes, scaled vector and squared terms.
  logic [GrayInputs-1:0] lane_bit;

  for (genvar l = 0; l < GrayInputs; l++) begin : g_lane
    gcpsd_lane u_lane (
      .sample_i (gs1_q[l]),
      .lo_i     (lo1_q),
      .span_i   (span1_q),
      .thr_i    (thr_q),
      .bit_o    (lane_bit[l])
    );
  end

  logic signed [XyW-1:0] x2_q, y2_q;
  logic [17:0]           sqa2_q;
  logic [15:0]           sqb2_q;
  logic                  three2_q;
  logic [GrayInputs-1:0] bits2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q     <= XyW'(cx1_q) <<< Q20Shift;
      y2_q     <= three1_q ? XyW'(dd1_q * SQRT3_Q20) : (XyW'(dd1_q) <<< Q20Shift);
      sqa2_q   <= 18'(cx1_q * cx1_q);
      sqb2_q   <= 16'(dd1_q * dd1_q);
      three2_q <= three1_q;
      bits2_q  <= lane_bit;
    end
  end

  // Merge: the lane bits form the short and long Gray codes, sample 0 first.
  // Bits taken beyond the last Gray sample read as zero.
  logic [GRAY_BITS-1:0] code1, bin1;
  logic [LongW-1:0]     code2, bin2;
  logic [KW-1:0]        k1, k2;

  always_comb begin
    for (int i = 0; i < GRAY_BITS; i++) begin
      code1[GRAY_BITS-1-i] = (i < GrayInputs) ? bits2_q[i] : 1'b0;
    end
    for (int i = 0; i < LongW; i++) begin
      code2[LongW-1-i] = (i < GrayInputs) ? bits2_q[i] : 1'b0;
    end
    bin1[GRAY_BITS-1] = code1[GRAY_BITS-1];
    for (int j = GRAY_BITS - 2; j >= 0; j--) bin1[j] = bin1[j+1] ^ code1[j];
    bin2[LongW-1] = code2[LongW-1];
    for (int j = LongW - 2; j >= 0; j--) bin2[j] = bin2[j+1] ^ code2[j];
    k1 = KW'(bin1);
    k2 = (KW'(bin2) + KW'(1)) >> 1;
  end

  // Angle and modulation pipelines.
  logic [AngW-1:0]   ang;
  logic [SumSqW-1:0] sumsq;
  logic [7:0]        mod;

  assign sumsq = three2_q ? SumSqW'(sqa2_q) + SumSqW'(sqb2_q) + (SumSqW'(sqb2_q) << 1)
                          : SumSqW'(sqa2_q) + SumSqW'(sqb2_q);

  gcpsd_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x2_q),
    .y_i   (y2_q),
    .ang_o (ang)
  );

  gcpsd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .en_i    (en),
    .sumsq_i (sumsq),
    .three_i (three2_q),
    .mod_o   (mod)
  );

  // Alignment of the orders and the modulation with the angle.
  logic [KW-1:0] k1d_q [KDly];
  logic [KW-1:0] k2d_q [KDly];
  logic [7:0]    modd_q [MDly];

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1d_q[0]  <= k1;
      k2d_q[0]  <= k2;
      modd_q[0] <= mod;
      for (int i = 1; i < KDly; i++) begin
        k1d_q[i] <= k1d_q[i-1];
        k2d_q[i] <= k2d_q[i-1];
      end
      for (int i = 1; i < MDly; i++) modd_q[i] <= modd_q[i-1];
    end
  end

  // Complementary unwrapping: near the period edges the long code's rounded
  // order is used, in the middle the short code's order.
  logic [AngW-1:0]            t32;
  logic [PHASE_FRAC_BITS-1:0] t;
  logic signed [KW:0]         k;
  logic signed [WideW-1:0]    wide;

  always_comb begin
    t32 = ANG_ZERO - ang;
    t   = t32[AngW-1 -: PHASE_FRAC_BITS];
    if (t32 <= ANG_QUARTER) begin
      k = signed'({1'b0, k2d_q[KDly-1]});
    end else if (t32 >= ANG_3QUART) begin
      k = signed'({1'b0, k2d_q[KDly-1]}) - (KW+1)'(1);
    end else begin
      k = signed'({1'b0, k1d_q[KDly-1]});
    end
    wide = (WideW'(k) <<< PHASE_FRAC_BITS) + WideW'(t);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unwrapped_phase_o <= wide[21:0];
      modulation_o      <= modd_q[MDly-1];
    end
  end

endmodule
`default_nettype wire

[design/gcpsd_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcpsd_lane: one Gray sample binarizer
// Compares the sample's offset above the pixel minimum with the scaled span.
// ----------------------------------------------------------------------------
module gcpsd_lane
  import gcpsd_pkg::*;
(
  input  wire logic [7:0] sample_i,
  input  wire logic [7:0] lo_i,
  input  wire logic [7:0] span_i,
  input  wire logic [7:0] thr_i,
  output logic            bit_o
);

  logic [7:0]  offs;
  logic [15:0] scaled;

  assign offs   = sample_i - lo_i;
  assign scaled = 16'(thr_i) * 16'(span_i);
  assign bit_o  = {offs, 8'h00} > scaled;

endmodule
`default_nettype wire

[design/gcpsd_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcpsd_cordic: pipelined vectoring CORDIC giving atan2 as a turn fraction
// One setup stage handles the axes and the left half plane, then one stage
// per iteration. All stages advance together on en_i.
// ----------------------------------------------------------------------------
module gcpsd_cordic
  import gcpsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [XyW-1:0] x_i,
  input  wire logic signed [XyW-1:0] y_i,
  output logic [AngW-1:0]            ang_o
);

  logic signed [XyW-1:0] x_q [0:CordicIters];
  logic signed [XyW-1:0] y_q [0:CordicIters];
  logic [AngW-1:0]       z_q [0:CordicIters];
  logic                  hold_q [0:CordicIters];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_i;
      y_q[0]    <= y_i;
      z_q[0]    <= ANG_ZERO;
      hold_q[0] <= 1'b0;
      if (y_i == '0) begin
        hold_q[0] <= 1'b1;
        z_q[0]    <= (x_i < 0) ? ANG_HALF : ANG_ZERO;
      end else if (x_i == '0) begin
        hold_q[0] <= 1'b1;
        z_q[0]    <= (y_i > 0) ? ANG_QUARTER : ANG_3QUART;
      end else if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= ANG_HALF;
      end
    end
  end

  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    logic signed [XyW-1:0] dx, dy;
    // Each coordinate moves by the other one shifted down, rounded to floor.
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hold_q[i+1] <= hold_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= hold_q[i] ? z_q[i] : z_q[i] + ATAN_TURN[i];
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= hold_q[i] ? z_q[i] : z_q[i] - ATAN_TURN[i];
        end
      end
    end
  end

  assign ang_o = z_q[CordicIters];

endmodule
`default_nettype wire

[design/gcpsd_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcpsd_isqrt: pipelined integer square root and modulation scaling
// One stage per result bit, then a divide by two or three and saturation.
// ----------------------------------------------------------------------------
module gcpsd_isqrt
  import gcpsd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [SumSqW-1:0] sumsq_i,
  input  wire logic              three_i,
  output logic [7:0]             mod_o
);

  logic [SumSqW-1:0] m_q [0:IsqrtIters];
  logic [SumSqW-1:0] r_q [0:IsqrtIters];
  logic              t_q [0:IsqrtIters];
  logic [7:0]        mod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= sumsq_i;
      r_q[0] <= '0;
      t_q[0] <= three_i;
    end
  end

  for (genvar i = 0; i < IsqrtIters; i++) begin : g_iter
    localparam logic [SumSqW-1:0] Bit = SumSqW'(1) << (2 * (IsqrtIters - 1 - i));
    logic [SumSqW-1:0] trial;
    assign trial = r_q[i] + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[i+1] <= t_q[i];
        if (m_q[i] >= trial) begin
          m_q[i+1] <= m_q[i] - trial;
          r_q[i+1] <= (r_q[i] >> 1) + Bit;
        end else begin
          m_q[i+1] <= m_q[i];
          r_q[i+1] <= r_q[i] >> 1;
        end
      end
    end
  end

  logic [RootW-1:0] root;
  logic [21:0]      prod3;
  logic [RootW-1:0] quot;

  always_comb begin
    root  = r_q[IsqrtIters][RootW-1:0];
    prod3 = 22'(root) * 22'(RECIP3);
    quot  = t_q[IsqrtIters] ? RootW'(prod3 >> 11) : (root >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mod_q <= (quot > RootW'(255)) ? 8'd255 : quot[7:0];
    end
  end

  assign mod_o = mod_q;

endmodule
`default_nettype wire

[design/gcpsd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcpsd_checker: port-level assertions for the decoder
// Watches the request handshakes and the pipeline hold behavior.
// ----------------------------------------------------------------------------
module gcpsd_checker
  import gcpsd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [21:0] unwrapped_phase_o,
  input wire logic [7:0]         modulation_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(unwrapped_phase_o) && $stable(modulation_o))
    else $error("stalled result changed");

  // The input stalls exactly when a finished result is held at the output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

  // Once reset has been seen at an edge, nothing is offered and nothing is
  // refused at the following edge.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind gray_code_phase_shift_decoder gcpsd_checker u_gcpsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .unwrapped_phase_o (unwrapped_phase_o),
  .modulation_o      (modulation_o)
);
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Gray code phase shift decoder
// Drives pixel requests through a random valid/stall handshake, predicts each
// unwrapped phase and modulation with an independent fixed-point model and
// compares every result in order against the queue of predictions.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gcpsd_pkg::*;

  // A pixel request as it crosses the input handshake.
  typedef struct packed {
    logic [7:0] ph0, ph1, ph2, ph3;
    logic [7:0] g0, g1, g2, g3, g4;
    logic [7:0] blk, wht;
  } pixel_t;

  // One decoded pixel, as predicted for the output side.
  typedef struct packed {
    logic [21:0] phase;
    logic [7:0]  modu;
  } decoded_t;

  localparam int PipeDepth = 32;
  localparam int WatchLimit = 20000;
  localparam int PixW = $bits(pixel_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pixel_t pix = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [21:0] phase_out;
  logic [7:0] modu_out;

  // The bench keeps its own copy of the two registers.
  logic [2:0] steps_q = STEPS_RESET;
  logic [7:0] thresh_q = THRESHOLD_RESET;

  decoded_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_mode = 1'b0;   // no idling in the final part of the run
  int hold_off = 0;        // long receiver hold-off, counted by its own process

  always #10 clk = ~clk;

  gray_code_phase_shift_decoder dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .phase_sample_0_i(pix.ph0), .phase_sample_1_i(pix.ph1),
    .phase_sample_2_i(pix.ph2), .phase_sample_3_i(pix.ph3),
    .gray_sample_0_i(pix.g0), .gray_sample_1_i(pix.g1), .gray_sample_2_i(pix.g2),
    .gray_sample_3_i(pix.g3), .gray_sample_4_i(pix.g4),
    .black_sample_i(pix.blk), .white_sample_i(pix.wht),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .unwrapped_phase_o(phase_out), .modulation_o(modu_out)
  );

  // Floor division by a power of two on signed values.
  function automatic longint floor_div2(longint v, int k);
    return v >>> k;
  endfunction

  // Angle of (x,y) as an unsigned fraction of a turn, by CORDIC vectoring.
  function automatic logic [31:0] cordic_turns(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = ANG_ZERO;
    if (y == 0) return (x < 0) ? ANG_HALF : ANG_ZERO;
    if (x == 0) return (y > 0) ? ANG_QUARTER : ANG_3QUART;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = ANG_HALF;
    end
    for (int i = 0; i < CordicIters; i++) begin
      dx = floor_div2(y, i);
      dy = floor_div2(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TURN[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TURN[i];
      end
    end
    return z;
  endfunction

  // Exact integer square root, rounded down.
  function automatic int unsigned root_floor(int unsigned m);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= m) r++;
    return r;
  endfunction

  function automatic int unsigned gray_decode(int unsigned g);
    int unsigned b;
    b = g;
    while (g != 0) begin
      g >>= 1;
      b ^= g;
    end
    return b;
  endfunction

  function automatic decoded_t decode_pixel(pixel_t p);
    decoded_t d;
    int s[11];
    int lo, hi, span, cx, dd;
    int unsigned m, short_code, long_code, k1, k2;
    longint x, y, t, ord, res;
    logic [31:0] t32;
    s = '{p.ph0, p.ph1, p.ph2, p.ph3, p.g0, p.g1, p.g2, p.g3, p.g4, p.blk, p.wht};
    if (steps_q == STEPS_THREE) begin
      cx = 2 * s[0] - s[1] - s[2];
      dd = s[1] - s[2];
      x = longint'(cx) <<< Q20Shift;
      y = longint'(dd) * longint'(SQRT3_Q20);
      m = root_floor(cx * cx + 3 * dd * dd) / 3;
    end else begin
      cx = s[0] - s[2];
      dd = s[1] - s[3];
      x = longint'(cx) <<< Q20Shift;
      y = longint'(dd) <<< Q20Shift;
      m = root_floor(cx * cx + dd * dd) / 2;
    end
    if (m > 255) m = 255;
    lo = s[4];
    hi = s[4];
    for (int i = 5; i < 11; i++) begin
      if (s[i] < lo) lo = s[i];
      if (s[i] > hi) hi = s[i];
    end
    span = hi - lo;
    short_code = 0;
    long_code = 0;
    // The short code takes the first four Gray bits, the long code all five.
    for (int i = 0; i < GrayInputs; i++) begin
      bit b;
      b = ((s[4 + i] - lo) * 256) > (int'(thresh_q) * span);
      if (i < GrayInputs - 1) short_code = (short_code << 1) | b;
      long_code = (long_code << 1) | b;
    end
    k1 = gray_decode(short_code);
    k2 = (gray_decode(long_code) + 1) >> 1;
    t32 = 32'd0 - cordic_turns(x, y);
    t = longint'(t32 >> 16);
    if (t32 <= ANG_QUARTER) ord = k2;
    else if (t32 >= ANG_3QUART) ord = longint'(k2) - 1;
    else ord = k1;
    res = (ord <<< 16) + t;
    d.phase = res[21:0];
    d.modu = m[7:0];
    return d;
  endfunction

  // Sends one request and queues its prediction once it is accepted.
  task automatic send_pixel(pixel_t p);
    int gap;
    if (!quiet_mode && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pix <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, decode_pixel(p)};
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PHASE_STEPS) steps_q = val[2:0];
    else thresh_q = val;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = PixW'({$urandom, $urandom, $urandom});
    return p;
  endfunction

  // Well-formed structured-light pixel: Gray samples sit at dark or bright
  // levels with noise, phase samples are random.
  function automatic pixel_t lit_pixel();
    pixel_t p;
    int dark, bright;
    dark = $urandom_range(0, 60);
    bright = $urandom_range(150, 255);
    p = rand_pixel();
    p.blk = 8'(dark);
    p.wht = 8'(bright);
    p.g0 = $urandom_range(1) ? 8'(bright - $urandom_range(10)) : 8'(dark + $urandom_range(10));
    p.g1 = $urandom_range(1) ? 8'(bright - $urandom_range(10)) : 8'(dark + $urandom_range(10));
    p.g2 = $urandom_range(1) ? 8'(bright - $urandom_range(10)) : 8'(dark + $urandom_range(10));
    p.g3 = $urandom_range(1) ? 8'(bright - $urandom_range(10)) : 8'(dark + $urandom_range(10));
    p.g4 = $urandom_range(1) ? 8'(bright - $urandom_range(10)) : 8'(dark + $urandom_range(10));
    return p;
  endfunction

  task automatic test_directed_extremes;
    pixel_t p;
    p = '0;                       // flat pixel and zero sums
    send_pixel(p);
    p = '1;
    send_pixel(p);
    p = '0;
    p.ph0 = 8'd255;               // positive x axis
    send_pixel(p);
    p = '0;
    p.ph2 = 8'd255;               // negative x axis
    send_pixel(p);
    p = '0;
    p.ph1 = 8'd255;               // positive y axis
    send_pixel(p);
    p = '0;
    p.ph3 = 8'd255;               // negative y axis
    send_pixel(p);
    p = '0;
    p.ph0 = 8'd255;
    p.ph1 = 8'd255;               // largest modulation
    send_pixel(p);
    p = '0;
    p.ph2 = 8'd1;
    p.ph3 = 8'd255;               // near the low zone boundary
    send_pixel(p);
    p = '0;
    p.wht = 8'd255;
    p.g0 = 8'd255;
    p.g2 = 8'd255;
    p.g4 = 8'd255;
    send_pixel(p);
    p.g0 = 8'd128;                // sample right on the default threshold
    p.g1 = 8'd129;
    send_pixel(p);
    p = {8'd10, 8'd200, 8'd250, 8'd3, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
         8'd0, 8'd255};
    send_pixel(p);
    end_burst();
    wait_drained();
  endtask

  task automatic test_three_step;
    pixel_t p;
    write_reg(REG_PHASE_STEPS, {5'd0, STEPS_THREE});
    p = '0;
    p.ph0 = 8'd255;
    send_pixel(p);
    p = '0;
    p.ph1 = 8'd255;
    p.ph3 = 8'd77;                // ignored in three-step
    send_pixel(p);
    p = '0;
    p.ph2 = 8'd255;
    send_pixel(p);
    p = '0;
    p.ph1 = 8'd255;
    p.ph2 = 8'd255;               // strongest three-step vector
    send_pixel(p);
    for (int i = 0; i < 150; i++) send_pixel($urandom_range(3) == 0 ? rand_pixel()
                                                                    : lit_pixel());
    end_burst();
    wait_drained();
  endtask

  task automatic test_thresholds;
    logic [7:0] thr[4];
    thr = '{8'd0, 8'd255, 8'd64, 8'd200};
    write_reg(REG_PHASE_STEPS, {5'd0, STEPS_RESET});
    foreach (thr[j]) begin
      write_reg(REG_BIN_THRESHOLD, thr[j]);
      for (int i = 0; i < 100; i++) send_pixel($urandom_range(3) == 0 ? rand_pixel()
                                                                      : lit_pixel());
      end_burst();
      wait_drained();
    end
  endtask

  task automatic test_odd_steps;
    logic [2:0] odd[3];
    odd = '{3'd0, 3'd7, 3'd2};    // every value but three acts as four-step
    foreach (odd[j]) begin
      write_reg(REG_PHASE_STEPS, {5'd0, odd[j]});
      for (int i = 0; i < 40; i++) send_pixel(lit_pixel());
      end_burst();
      wait_drained();
    end
  endtask

  task automatic test_backpressure;
    write_reg(REG_PHASE_STEPS, {5'd0, STEPS_RESET});
    write_reg(REG_BIN_THRESHOLD, THRESHOLD_RESET);
    hold_off = 120;               // receiver stalls while the sender fills the pipe
    for (int i = 0; i < 80; i++) send_pixel(lit_pixel());
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);   // sender waits for drain
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
    end_burst();
    wait_drained();
  endtask

  task automatic test_quiet_stream;
    quiet_mode = 1'b1;
    write_reg(REG_PHASE_STEPS, {5'd0, STEPS_THREE});
    for (int i = 0; i < 100; i++) send_pixel(lit_pixel());
    end_burst();
    wait_drained();
  endtask

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (!quiet_mode && $urandom_range(4) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: phase %0h modulation %0d",
                 $time, phase_out, modu_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (phase_out !== want.phase) begin
          $display("%0t: unwrapped_phase expected %0h actual %0h", $time,
                   want.phase, phase_out);
          errors++;
        end
        if (modu_out !== want.modu) begin
          $display("%0t: modulation expected %0d actual %0d", $time,
                   want.modu, modu_out);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no request or result is accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_three_step();
    test_thresholds();
    test_odd_steps();
    test_backpressure();
    test_quiet_stream();
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
design/gcpsd_pkg.sv
design/gcpsd_lane.sv
design/gcpsd_cordic.sv
design/gcpsd_isqrt.sv
design/gray_code_phase_shift_decoder.sv
design/gcpsd_checker.sv
tb/tb_top.sv
